[sv/mqtt_packet_deframer_top_assert.svh]
// Assertion macros for the deframer. Each expects clk and arst_n in scope.
`ifndef MQTT_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define MQTT_PACKET_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MQD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MQD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mqd_pkg.sv]
package mqd_pkg;

	localparam int unsigned LenW   = 28;
	localparam int unsigned TotalW = 29;
	localparam int unsigned HlenW  = 3;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_LENGTH = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              packet_start;
		logic              in_header;
		logic              packet_end;
		logic [3:0]        packet_type;
		logic [3:0]        packet_flags;
		logic [LenW-1:0]   length_field;
		logic [TotalW-1:0] total_length;
	} out_item_t;

endpackage

[sv/mqd_stream_if.sv]
interface mqd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/mqtt_packet_deframer_top.sv]
// Channel   Direction  Payload      Handshake
// in_ch     sink       in_item_t    valid/ready, item taken when both high
// out_ch    source     out_item_t   valid/ready, item taken when both high
//
// One item is taken per clock unless out_ch stalls; its result passes stage one, then stage two.
// The rate is set by the single state update in stage one (phase, length, count).
// An asynchronous low on arst_n empties both stages and returns to the first-byte phase.
// A stall on out_ch holds both stages; in_ch stays ready while stage one can move or is empty.
`include "mqtt_packet_deframer_top_assert.svh"

module mqtt_packet_deframer_top (
	input logic clk,
	input logic arst_n,
	mqd_stream_if.sink in_ch,
	mqd_stream_if.source out_ch
);
	import mqd_pkg::*;

	// Stage one: input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	// Stage two: result register.
	logic       valid_s2;
	out_item_t  out_s2;

	// Running packet state.
	phase_t            phase_q;
	logic [HlenW-1:0]  hlen_q;
	logic [LenW-1:0]   acc_q;
	logic [TotalW-1:0] cnt_q;
	logic [3:0]        type_q;
	logic [3:0]        flags_q;

	phase_t            phase_n;
	logic [HlenW-1:0]  hlen_n;
	logic [LenW-1:0]   acc_n;
	logic [TotalW-1:0] cnt_n;
	logic [3:0]        type_n;
	logic [3:0]        flags_n;
	logic [1:0]        grp;
	logic [TotalW-1:0] total;
	logic              start;
	logic              hdr;
	logic              pkt_end;
	out_item_t         res;

	logic adv_s1;
	logic take_in;

	assign adv_s1      = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign take_in     = in_ch.valid && in_ch.ready;

	always_comb begin
		phase_n = phase_q;
		hlen_n  = hlen_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		type_n  = type_q;
		flags_n = flags_q;
		start   = 1'b0;
		hdr     = 1'b0;
		grp     = cnt_q[1:0] - 2'd1;
		unique case (phase_q)
			PH_LENGTH: begin
				// Each 7-bit group lands in bits still clear, so an OR places it.
				case (grp)
					2'd0: acc_n[6:0]   = acc_q[6:0] | byte_s1[6:0];
					2'd1: acc_n[13:7]  = acc_q[13:7] | byte_s1[6:0];
					2'd2: acc_n[20:14] = acc_q[20:14] | byte_s1[6:0];
					default: acc_n[27:21] = acc_q[27:21] | byte_s1[6:0];
				endcase
				cnt_n = cnt_q + 1'b1;
				hdr   = 1'b1;
				if (byte_s1[7] && grp != 2'd3) begin
					hlen_n = hlen_q + 1'b1;
				end else begin
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				cnt_n = cnt_q + 1'b1;
			end
			default: begin
				type_n  = byte_s1[7:4];
				flags_n = byte_s1[3:0];
				hlen_n  = HlenW'(2);
				acc_n   = '0;
				cnt_n   = TotalW'(1);
				phase_n = PH_LENGTH;
				start   = 1'b1;
				hdr     = 1'b1;
			end
		endcase

		total   = {{(TotalW-HlenW){1'b0}}, hlen_n} + {1'b0, acc_n};
		pkt_end = (phase_n == PH_BODY) && (cnt_n >= total);

		res.out_byte     = byte_s1;
		res.packet_start = start;
		res.in_header    = hdr;
		res.packet_end   = pkt_end;
		res.packet_type  = type_n;
		res.packet_flags = flags_n;
		res.length_field = pkt_end ? acc_n : '0;
		res.total_length = pkt_end ? total : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_FIRST;
			hlen_q   <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			type_q   <= '0;
			flags_q  <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && adv_s1) begin
				if (pkt_end) begin
					phase_q <= PH_FIRST;
					hlen_q  <= '0;
					acc_q   <= '0;
					cnt_q   <= '0;
					type_q  <= '0;
					flags_q <= '0;
				end else begin
					phase_q <= phase_n;
					hlen_q  <= hlen_n;
					acc_q   <= acc_n;
					cnt_q   <= cnt_n;
					type_q  <= type_n;
					flags_q <= flags_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= in_ch.data.data_byte;
		end
		if (valid_s1 && adv_s1) begin
			out_s2 <= res;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = out_s2;

	`MQD_ASSERT_IMP(a_start_in_header, valid_s2 && out_s2.packet_start,
		out_s2.in_header, "packet start outside the fixed header")
	`MQD_ASSERT_IMP(a_idle_lengths_zero, valid_s2 && !out_s2.packet_end,
		out_s2.length_field == '0 && out_s2.total_length == '0,
		"lengths shown on a byte that does not end a packet")
	`MQD_ASSERT_IMP(a_header_span, valid_s2 && out_s2.packet_end,
		{1'b0, out_s2.length_field} + TotalW'(2) <= out_s2.total_length &&
		out_s2.total_length <= {1'b0, out_s2.length_field} + TotalW'(5),
		"total length disagrees with a fixed header of two to five bytes")
	`MQD_ASSERT_NEXT(a_end_clears, valid_s1 && adv_s1 && pkt_end,
		phase_q == PH_FIRST && cnt_q == '0,
		"packet state not cleared after the closing item")

endmodule
